@@ hdl/ssa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ssa_pkg;

    // Series length limit; counts and run lengths saturate here.
    localparam int MAX_SERIES = 65536;
    localparam int CNT_W      = $clog2(MAX_SERIES) + 1;

    // Widths fixed by the data format.
    localparam int SMP_W  = 32;
    localparam int SUM_W  = 48;
    localparam int ALU_W  = SUM_W + 1;
    localparam int DIFF_W = SMP_W + 1;
    localparam int FRAC_BITS = 16;
    localparam int STEP_W = $clog2(SUM_W);

    // Statistic selected by the mode register.
    localparam logic [3:0] MODE_MEAN      = 4'd0;
    localparam logic [3:0] MODE_MAX       = 4'd1;
    localparam logic [3:0] MODE_MIN       = 4'd2;
    localparam logic [3:0] MODE_SUM       = 4'd3;
    localparam logic [3:0] MODE_EXCESS    = 4'd4;
    localparam logic [3:0] MODE_SHORTFALL = 4'd5;
    localparam logic [3:0] MODE_CNT_ABOVE = 4'd6;
    localparam logic [3:0] MODE_CNT_BELOW = 4'd7;
    localparam logic [3:0] MODE_RUN_ABOVE = 4'd8;
    localparam logic [3:0] MODE_RUN_BELOW = 4'd9;
    localparam logic [3:0] MODE_FRAC_POS  = 4'd10;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MODE      = 2'd0;
    localparam logic [1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [1:0] CFG_MISSING   = 2'd2;

    // Missing code after reset: -9999.0 in Q16.16.
    localparam logic [SMP_W-1:0] MISSING_RESET = 32'hD8F1_0000;

endpackage

`default_nettype wire

@@ hdl/series_statistics_aggregator_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Streaming statistics reducer. Signed Q16.16 samples arrive one word at a
// time; the word marked last closes the series and produces one result word
// (signed Q32.16) holding the statistic chosen by the mode register, with an
// invalid flag that marks the result as the missing code. Every sample takes
// three steps: one to accept it, one compare and one accumulate step, both
// on a single shared 49-bit adder. The last sample adds two more steps, one
// to form the result and one to move it into the output register, plus 49
// more for the mean and for the positive fraction, where the same adder runs
// a 48-step restoring division followed by a sign fix. The input side is
// ready again as soon as the finished result moves to the output register,
// so a result waiting there does not block the next series; it only holds
// the sequencer when a second result is ready before the first was taken.
// Configuration must be written only while the block is idle.
module series_statistics_aggregator_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write port.
    input  wire logic        i_cfg_wr_en,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_wdata,
    // Sample channel.
    input  wire logic        i_in_valid,
    output      logic        o_in_ready,
    input  wire logic [31:0] i_sample,
    input  wire logic        i_last,
    // Result channel.
    output      logic        o_out_valid,
    input  wire logic        i_out_ready,
    output      logic [47:0] o_result,
    output      logic        o_invalid
);

    localparam int CW = ssa_pkg::CNT_W;
    localparam int AW = ssa_pkg::ALU_W;
    localparam int SW = ssa_pkg::SUM_W;
    localparam int PW = ssa_pkg::SMP_W;
    localparam int DW = ssa_pkg::DIFF_W;
    localparam int FB = ssa_pkg::FRAC_BITS;
    localparam int QW = ssa_pkg::STEP_W;
    localparam logic [CW-1:0] CNT_MAX = CW'(ssa_pkg::MAX_SERIES);
    localparam logic [QW-1:0] LAST_STEP = QW'(SW - 1);

    // Sequencer states, one-hot.
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_CMP  = 7'b0000010,
        S_ACC  = 7'b0000100,
        S_PREP = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_SIGN = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers.
    logic [3:0]    r_mode;
    logic [PW-1:0] r_threshold;
    logic [PW-1:0] r_missing;

    // Captured sample.
    logic [PW-1:0] r_sample;
    logic          r_last;

    // Series state.
    logic [SW-1:0] r_sum, n_sum;
    logic [CW-1:0] r_valid_cnt, n_valid_cnt;
    logic [CW-1:0] r_total_cnt, n_total_cnt;
    logic [PW-1:0] r_extreme, n_extreme;
    logic [CW-1:0] r_cur_run, n_cur_run;
    logic [CW-1:0] r_long_run, n_long_run;

    // Compare step results.
    logic [DW-1:0] r_diff, n_diff;
    logic          r_gt, n_gt;

    // Divider and result staging.
    logic [SW-1:0] r_quo, n_quo;
    logic [CW:0]   r_rem, n_rem;
    logic [QW-1:0] r_step, n_step;
    logic          r_neg, n_neg;
    logic [SW-1:0] r_res, n_res;
    logic          r_bad, n_bad;

    // Output register.
    logic          r_out_valid, n_out_valid;
    logic [SW-1:0] r_out_result, n_out_result;
    logic          r_out_invalid, n_out_invalid;

    // Shared adder operands.
    logic signed [AW-1:0] alu_a, alu_b, alu_sum;
    logic                 alu_sub;

    logic          missing;
    logic          thr_bad;
    logic [CW-1:0] run_inc;
    logic [CW:0]   rem_sh;
    logic [CW-1:0] divisor;
    logic [SW-1:0] sum_sat;
    logic          out_free;

    ssa_addsub u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_sub (alu_sub),
        .o_sum (alu_sum)
    );

    assign missing  = (r_sample == r_missing);
    assign thr_bad  = (r_threshold == r_missing);
    assign run_inc  = (r_cur_run < CNT_MAX) ? r_cur_run + 1'b1 : r_cur_run;
    assign rem_sh   = {r_rem[CW-1:0], r_quo[SW-1]};
    assign divisor  = (r_mode == ssa_pkg::MODE_FRAC_POS) ? r_total_cnt : r_valid_cnt;
    assign out_free = !r_out_valid || i_out_ready;

    // The accumulate step saturates the sum to the signed 48-bit range.
    always_comb begin
        if (alu_sum[AW-1] != alu_sum[AW-2]) begin
            sum_sat = alu_sum[AW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end else begin
            sum_sat = alu_sum[SW-1:0];
        end
    end

    // Operand selection for the shared adder.
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (r_state)
            S_CMP: begin
                alu_sub = 1'b1;
                unique case (r_mode)
                    ssa_pkg::MODE_MAX: begin
                        alu_a = AW'($signed(r_sample));
                        alu_b = AW'($signed(r_extreme));
                    end
                    ssa_pkg::MODE_MIN: begin
                        alu_a = AW'($signed(r_extreme));
                        alu_b = AW'($signed(r_sample));
                    end
                    ssa_pkg::MODE_EXCESS, ssa_pkg::MODE_CNT_ABOVE,
                    ssa_pkg::MODE_RUN_ABOVE: begin
                        alu_a = AW'($signed(r_sample));
                        alu_b = AW'($signed(r_threshold));
                    end
                    ssa_pkg::MODE_SHORTFALL, ssa_pkg::MODE_CNT_BELOW,
                    ssa_pkg::MODE_RUN_BELOW: begin
                        alu_a = AW'($signed(r_threshold));
                        alu_b = AW'($signed(r_sample));
                    end
                    default: begin
                        // Positive test against zero.
                        alu_a = AW'($signed(r_sample));
                    end
                endcase
            end
            S_ACC: begin
                alu_a = AW'($signed(r_sum));
                if (r_mode == ssa_pkg::MODE_MEAN || r_mode == ssa_pkg::MODE_SUM) begin
                    alu_b = AW'($signed(r_sample));
                end else begin
                    alu_b = AW'($signed(r_diff));
                end
            end
            S_PREP: begin
                // Magnitude of a negative sum ahead of the division.
                alu_sub = 1'b1;
                alu_b   = AW'($signed(r_sum));
            end
            S_DIV: begin
                alu_sub = 1'b1;
                alu_a   = $signed(AW'(rem_sh));
                alu_b   = $signed(AW'(divisor));
            end
            S_SIGN: begin
                alu_sub = 1'b1;
                alu_b   = $signed({1'b0, r_quo});
            end
            default: begin
                alu_a = '0;
            end
        endcase
    end

    // Sequencer.
    always_comb begin
        n_state       = r_state;
        n_sum         = r_sum;
        n_valid_cnt   = r_valid_cnt;
        n_total_cnt   = r_total_cnt;
        n_extreme     = r_extreme;
        n_cur_run     = r_cur_run;
        n_long_run    = r_long_run;
        n_diff        = r_diff;
        n_gt          = r_gt;
        n_quo         = r_quo;
        n_rem         = r_rem;
        n_step        = r_step;
        n_neg         = r_neg;
        n_res         = r_res;
        n_bad         = r_bad;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_out_result  = r_out_result;
        n_out_invalid = r_out_invalid;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_diff  = alu_sum[DW-1:0];
                n_gt    = !alu_sum[AW-1] && (alu_sum != '0);
                n_state = S_ACC;
            end
            S_ACC: begin
                unique case (r_mode)
                    ssa_pkg::MODE_MEAN: begin
                        if (!missing) begin
                            n_sum = sum_sat;
                            if (r_valid_cnt < CNT_MAX) n_valid_cnt = r_valid_cnt + 1'b1;
                        end
                    end
                    ssa_pkg::MODE_MAX, ssa_pkg::MODE_MIN: begin
                        if (r_total_cnt == '0 || r_gt) n_extreme = r_sample;
                    end
                    ssa_pkg::MODE_SUM: begin
                        n_sum = sum_sat;
                    end
                    ssa_pkg::MODE_EXCESS, ssa_pkg::MODE_SHORTFALL: begin
                        if (r_gt) n_sum = sum_sat;
                    end
                    ssa_pkg::MODE_CNT_ABOVE, ssa_pkg::MODE_CNT_BELOW,
                    ssa_pkg::MODE_FRAC_POS: begin
                        if (r_gt && r_valid_cnt < CNT_MAX) n_valid_cnt = r_valid_cnt + 1'b1;
                    end
                    ssa_pkg::MODE_RUN_ABOVE, ssa_pkg::MODE_RUN_BELOW: begin
                        // A missing sample breaks the run.
                        if (!missing && r_gt) begin
                            n_cur_run = run_inc;
                            if (run_inc > r_long_run) n_long_run = run_inc;
                        end else begin
                            n_cur_run = '0;
                        end
                    end
                    default: begin
                        n_sum = r_sum;
                    end
                endcase
                if (r_total_cnt < CNT_MAX) n_total_cnt = r_total_cnt + 1'b1;
                n_state = r_last ? S_PREP : S_IDLE;
            end
            S_PREP: begin
                n_bad   = 1'b0;
                n_res   = r_sum;
                n_rem   = '0;
                n_step  = '0;
                n_neg   = 1'b0;
                n_state = S_DONE;
                unique case (r_mode)
                    ssa_pkg::MODE_MEAN: begin
                        if (r_valid_cnt == '0) begin
                            n_bad = 1'b1;
                        end else begin
                            n_neg   = r_sum[SW-1];
                            n_quo   = r_sum[SW-1] ? alu_sum[SW-1:0] : r_sum;
                            n_state = S_DIV;
                        end
                    end
                    ssa_pkg::MODE_MAX, ssa_pkg::MODE_MIN: begin
                        n_res = SW'($signed(r_extreme));
                    end
                    ssa_pkg::MODE_SUM: begin
                        n_res = r_sum;
                    end
                    ssa_pkg::MODE_EXCESS, ssa_pkg::MODE_SHORTFALL: begin
                        n_bad = thr_bad;
                    end
                    ssa_pkg::MODE_CNT_ABOVE, ssa_pkg::MODE_CNT_BELOW: begin
                        n_bad = thr_bad;
                        n_res = SW'({r_valid_cnt, {FB{1'b0}}});
                    end
                    ssa_pkg::MODE_RUN_ABOVE, ssa_pkg::MODE_RUN_BELOW: begin
                        n_bad = thr_bad;
                        n_res = SW'({r_long_run, {FB{1'b0}}});
                    end
                    ssa_pkg::MODE_FRAC_POS: begin
                        n_quo   = SW'({r_valid_cnt, {FB{1'b0}}});
                        n_state = S_DIV;
                    end
                    default: begin
                        n_bad = 1'b1;
                    end
                endcase
            end
            S_DIV: begin
                // One restoring step: keep the trial difference when it is
                // not negative and shift the quotient bit in.
                if (alu_sum[AW-1]) begin
                    n_rem = rem_sh;
                    n_quo = {r_quo[SW-2:0], 1'b0};
                end else begin
                    n_rem = alu_sum[CW:0];
                    n_quo = {r_quo[SW-2:0], 1'b1};
                end
                n_step = r_step + 1'b1;
                if (r_step == LAST_STEP) n_state = S_SIGN;
            end
            S_SIGN: begin
                n_res   = r_neg ? alu_sum[SW-1:0] : r_quo;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_invalid = r_bad;
                    n_out_result  = r_bad ? SW'($signed(r_missing)) : r_res;
                    n_sum         = '0;
                    n_valid_cnt   = '0;
                    n_total_cnt   = '0;
                    n_extreme     = '0;
                    n_cur_run     = '0;
                    n_long_run    = '0;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= ssa_pkg::MODE_MEAN;
            r_threshold <= '0;
            r_missing   <= ssa_pkg::MISSING_RESET;
            r_sum       <= '0;
            r_valid_cnt <= '0;
            r_total_cnt <= '0;
            r_extreme   <= '0;
            r_cur_run   <= '0;
            r_long_run  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_valid_cnt <= n_valid_cnt;
            r_total_cnt <= n_total_cnt;
            r_extreme   <= n_extreme;
            r_cur_run   <= n_cur_run;
            r_long_run  <= n_long_run;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    ssa_pkg::CFG_MODE:      r_mode      <= i_cfg_wdata[3:0];
                    ssa_pkg::CFG_THRESHOLD: r_threshold <= i_cfg_wdata;
                    ssa_pkg::CFG_MISSING:   r_missing   <= i_cfg_wdata;
                    default:                r_mode      <= r_mode;
                endcase
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_sample <= i_sample;
            r_last   <= i_last;
        end
        r_diff        <= n_diff;
        r_gt          <= n_gt;
        r_quo         <= n_quo;
        r_rem         <= n_rem;
        r_step        <= n_step;
        r_neg         <= n_neg;
        r_res         <= n_res;
        r_bad         <= n_bad;
        r_out_result  <= n_out_result;
        r_out_invalid <= n_out_invalid;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out_result;
    assign o_invalid   = r_out_invalid;

endmodule

`default_nettype wire

@@ hdl/ssa_addsub.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Shared adder and subtractor of the sequencer. Compare steps, accumulations,
// sign changes and division trial subtractions pass through this one unit.
module ssa_addsub (
    input  wire logic signed [ssa_pkg::ALU_W-1:0] i_a,
    input  wire logic signed [ssa_pkg::ALU_W-1:0] i_b,
    input  wire logic                             i_sub,
    output      logic signed [ssa_pkg::ALU_W-1:0] o_sum
);

    logic [ssa_pkg::ALU_W-1:0] b_eff;

    assign b_eff = i_sub ? ~i_b : i_b;
    assign o_sum = i_a + $signed(b_eff) + $signed({{(ssa_pkg::ALU_W-1){1'b0}}, i_sub});

endmodule

`default_nettype wire
